[rtl/acfp_pkg.sv]
`default_nettype none
package acfp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_TYPE   = 3'd2,
    PH_ACCESS = 3'd3,
    PH_FIELD  = 3'd4,
    PH_SKIP   = 3'd5,
    PH_TAIL   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_HEADER_THIRD  = 2'd2,
    REG_IO_DISABLED   = 2'd3
  } reg_idx_t;

  typedef logic [10:0] param_t;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_D = 8'h44;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'd65;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd66;
  localparam logic [7:0] HEADER_THIRD_RST  = 8'd84;

  localparam logic [1:0] KIND_ANALOG  = 2'd0;
  localparam logic [1:0] KIND_DIGITAL = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;

  function automatic param_t cond_negate(input param_t v, input logic neg);
    cond_negate = neg ? param_t'(~v + 11'd1) : v;
  endfunction

endpackage
`default_nettype wire

[rtl/ascii_command_frame_parser.sv]
// ASCII command frame parser.
// Received bytes enter on the input channel (in_valid/in_ready, in_rx_byte),
// one per beat. The block hunts for the three-byte header set in the
// configuration registers, then decodes a type byte, an access byte and two
// signed decimal fields. Each '#' that closes a frame produces one beat on
// the result channel (out_valid/out_ready) carrying the decoded command, the
// blocked flag and a wrapping frame count. Frames longer than MAX_FRAME bytes
// are dropped without a result.
// An accepted byte is held in the input register and decoded from there once
// the result register is free; its '#' then loads the registered out_valid.
// The per-byte state update is a single pass of logic, so one byte is taken
// in every cycle as long as the result register is empty or is being drained.
// When the receiver stalls with a result pending, one more byte is held in the
// input register and in_ready drops until the result beat is taken.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to
// header hunting, clears the frame count and restores the header defaults.
// The APB-style port writes and reads the four configuration registers; it
// should be written only while no frame is in progress.
`default_nettype none
module ascii_command_frame_parser #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_command_kind,
  output logic [7:0]                  out_access_byte,
  output acfp_pkg::param_t            out_first_param,
  output acfp_pkg::param_t            out_second_param,
  output logic                        out_blocked,
  output logic [15:0]                 out_frame_number,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import acfp_pkg::*;

  localparam int FLEN_W = $clog2(MAX_FRAME + 1);
  localparam logic [FLEN_W-1:0] FLEN_MAX = FLEN_W'(MAX_FRAME);
  localparam logic [FLEN_W-1:0] FLEN_ONE = FLEN_W'(1);

  logic [7:0] header_first_r, header_second_r, header_third_r;
  logic       io_disabled_r;

  logic       st_valid_r;
  logic [7:0] st_byte_r;
  logic       fire;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        header_pos_r, header_pos_nxt;
  logic              field_sel_r, field_sel_nxt;
  logic [1:0]        field_chars_r, field_chars_nxt;
  logic              digits_done_r, digits_done_nxt;
  logic              field_negative_r, field_negative_nxt;
  param_t            first_value_r, first_value_nxt;
  param_t            second_value_r, second_value_nxt;
  logic [7:0]        type_char_r, type_char_nxt;
  logic [7:0]        access_char_r, access_char_nxt;
  logic [FLEN_W-1:0] frame_length_r, frame_length_nxt;
  logic [15:0]       frames_seen_r, frames_seen_nxt;
  logic              emit;

  logic              out_valid_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        access_out_r;
  param_t            first_out_r, second_out_r;
  logic              blocked_r, blocked_nxt;
  logic [15:0]       frame_number_r;

  logic       cfg_write;
  reg_idx_t   cfg_idx;

  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign pready    = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_HEADER_FIRST:  prdata = {24'd0, header_first_r};
      REG_HEADER_SECOND: prdata = {24'd0, header_second_r};
      REG_HEADER_THIRD:  prdata = {24'd0, header_third_r};
      REG_IO_DISABLED:   prdata = {31'd0, io_disabled_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
      header_third_r  <= HEADER_THIRD_RST;
      io_disabled_r   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_HEADER_FIRST:  header_first_r  <= pwdata[7:0];
        REG_HEADER_SECOND: header_second_r <= pwdata[7:0];
        REG_HEADER_THIRD:  header_third_r  <= pwdata[7:0];
        REG_IO_DISABLED:   io_disabled_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign fire     = st_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !st_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_byte_r <= in_rx_byte;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [7:0] want;
    param_t     cur;
    b = st_byte_r;
    want = 8'd0;
    cur = 11'd0;
    phase_nxt          = phase_r;
    header_pos_nxt     = header_pos_r;
    field_sel_nxt      = field_sel_r;
    field_chars_nxt    = field_chars_r;
    digits_done_nxt    = digits_done_r;
    field_negative_nxt = field_negative_r;
    first_value_nxt    = first_value_r;
    second_value_nxt   = second_value_r;
    type_char_nxt      = type_char_r;
    access_char_nxt    = access_char_r;
    frame_length_nxt   = frame_length_r;
    frames_seen_nxt    = frames_seen_r;
    emit               = 1'b0;
    if (fire) begin
      if (phase_nxt != PH_HUNT) begin
        if (frame_length_nxt >= FLEN_MAX) begin
          phase_nxt = PH_HUNT;
        end else begin
          frame_length_nxt = frame_length_nxt + FLEN_ONE;
        end
      end
      if (phase_nxt == PH_HUNT) begin
        if (b == header_first_r) begin
          phase_nxt          = PH_HEADER;
          header_pos_nxt     = 2'd1;
          frame_length_nxt   = FLEN_ONE;
          field_sel_nxt      = 1'b0;
          field_chars_nxt    = 2'd0;
          digits_done_nxt    = 1'b0;
          field_negative_nxt = 1'b0;
          first_value_nxt    = 11'd0;
          second_value_nxt   = 11'd0;
          type_char_nxt      = 8'd0;
          access_char_nxt    = 8'd0;
        end
      end else if (phase_nxt == PH_HEADER) begin
        want = (header_pos_nxt == 2'd1) ? header_second_r : header_third_r;
        if (b != want) begin
          phase_nxt = PH_HUNT;
        end else begin
          header_pos_nxt = header_pos_nxt + 2'd1;
          if (header_pos_nxt == 2'd3) begin
            phase_nxt = PH_TYPE;
          end
        end
      end else if (b == CH_SPACE) begin
        phase_nxt = phase_nxt;
      end else if (b == CH_HASH) begin
        if (phase_nxt == PH_FIELD) begin
          if (field_sel_nxt) begin
            second_value_nxt = cond_negate(second_value_nxt, field_negative_nxt);
          end else begin
            first_value_nxt = cond_negate(first_value_nxt, field_negative_nxt);
          end
          field_negative_nxt = 1'b0;
        end
        emit            = 1'b1;
        frames_seen_nxt = frames_seen_r + 16'd1;
        phase_nxt       = PH_HUNT;
      end else begin
        case (phase_nxt)
          PH_TYPE: begin
            type_char_nxt = b;
            phase_nxt     = PH_ACCESS;
          end
          PH_ACCESS: begin
            access_char_nxt    = b;
            field_sel_nxt      = 1'b0;
            field_chars_nxt    = 2'd0;
            digits_done_nxt    = 1'b0;
            field_negative_nxt = 1'b0;
            phase_nxt          = PH_FIELD;
          end
          PH_FIELD: begin
            if (b == CH_COMMA) begin
              if (field_sel_nxt) begin
                second_value_nxt = cond_negate(second_value_nxt, field_negative_nxt);
                phase_nxt        = PH_TAIL;
              end else begin
                first_value_nxt    = cond_negate(first_value_nxt, field_negative_nxt);
                field_sel_nxt      = 1'b1;
                field_chars_nxt    = 2'd0;
                digits_done_nxt    = 1'b0;
                phase_nxt          = PH_FIELD;
              end
              field_negative_nxt = 1'b0;
            end else begin
              cur = field_sel_nxt ? second_value_nxt : first_value_nxt;
              if (field_chars_nxt == 2'd0 && (b == CH_MINUS || b == CH_PLUS)) begin
                field_negative_nxt = (b == CH_MINUS);
              end else if (!digits_done_nxt && b >= CH_ZERO && b <= CH_NINE) begin
                cur = (cur << 3) + (cur << 1) + {7'd0, b[3:0]};
              end else begin
                digits_done_nxt = 1'b1;
              end
              field_chars_nxt = field_chars_nxt + 2'd1;
              if (field_chars_nxt == 2'd3) begin
                cur                = cond_negate(cur, field_negative_nxt);
                field_negative_nxt = 1'b0;
                phase_nxt          = PH_SKIP;
              end
              if (field_sel_nxt) begin
                second_value_nxt = cur;
              end else begin
                first_value_nxt = cur;
              end
            end
          end
          PH_SKIP: begin
            if (field_sel_nxt) begin
              phase_nxt = PH_TAIL;
            end else begin
              field_sel_nxt      = 1'b1;
              field_chars_nxt    = 2'd0;
              digits_done_nxt    = 1'b0;
              field_negative_nxt = 1'b0;
              phase_nxt          = PH_FIELD;
            end
          end
          default: phase_nxt = phase_nxt;
        endcase
      end
    end
  end

  always_comb begin
    if (type_char_nxt == CH_UPPER_A) begin
      kind_nxt = KIND_ANALOG;
    end else if (type_char_nxt == CH_UPPER_D) begin
      kind_nxt = KIND_DIGITAL;
    end else begin
      kind_nxt = KIND_OTHER;
    end
    blocked_nxt = (kind_nxt != KIND_OTHER) &&
                  (($signed(first_value_nxt) < $signed(11'sd2)) || io_disabled_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HUNT;
      header_pos_r     <= 2'd0;
      field_sel_r      <= 1'b0;
      field_chars_r    <= 2'd0;
      digits_done_r    <= 1'b0;
      field_negative_r <= 1'b0;
      first_value_r    <= 11'd0;
      second_value_r   <= 11'd0;
      type_char_r      <= 8'd0;
      access_char_r    <= 8'd0;
      frame_length_r   <= '0;
      frames_seen_r    <= 16'd0;
    end else begin
      phase_r          <= phase_nxt;
      header_pos_r     <= header_pos_nxt;
      field_sel_r      <= field_sel_nxt;
      field_chars_r    <= field_chars_nxt;
      digits_done_r    <= digits_done_nxt;
      field_negative_r <= field_negative_nxt;
      first_value_r    <= first_value_nxt;
      second_value_r   <= second_value_nxt;
      type_char_r      <= type_char_nxt;
      access_char_r    <= access_char_nxt;
      frame_length_r   <= frame_length_nxt;
      frames_seen_r    <= frames_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r         <= kind_nxt;
      access_out_r   <= access_char_nxt;
      first_out_r    <= first_value_nxt;
      second_out_r   <= second_value_nxt;
      blocked_r      <= blocked_nxt;
      frame_number_r <= frames_seen_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command_kind = kind_r;
  assign out_access_byte  = access_out_r;
  assign out_first_param  = first_out_r;
  assign out_second_param = second_out_r;
  assign out_blocked      = blocked_r;
  assign out_frame_number = frame_number_r;

endmodule
`default_nettype wire

[test/frame_decode_checker.sv]
`default_nettype none
module frame_decode_checker #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [1:0]        out_command_kind,
  input  wire logic [7:0]        out_access_byte,
  input  wire acfp_pkg::param_t  out_first_param,
  input  wire acfp_pkg::param_t  out_second_param,
  input  wire logic              out_blocked,
  input  wire logic [15:0]       out_frame_number,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output int                     pending,
  output int                     mismatches
);
  import acfp_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  access;
    param_t      first;
    param_t      second;
    logic        blocked;
    logic [15:0] number;
  } command_t;

  logic [7:0]  hdr[3];
  logic        io_off;
  phase_t      ph;
  int          hpos;
  int          flen;
  int          fsel;
  int          fchars;
  logic        digits_done;
  logic        fneg;
  param_t      fval[2];
  logic [7:0]  type_byte;
  logic [7:0]  access_byte;
  logic [15:0] frames;
  command_t    commands_q[$];
  command_t    want;
  int          bad = 0;

  initial begin
    pending = 0;
    mismatches = 0;
  end

  task automatic clear_field();
    fchars = 0;
    digits_done = 1'b0;
    fneg = 1'b0;
  endtask

  task automatic seal_field();
    if (fneg) fval[fsel] = -fval[fsel];
    fneg = 1'b0;
  endtask

  task automatic next_field();
    if (fsel == 0) begin
      fsel = 1;
      clear_field();
      ph = PH_FIELD;
    end else begin
      ph = PH_TAIL;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    command_t cmd;
    if (ph != PH_HUNT) begin
      if (flen >= MAX_FRAME) ph = PH_HUNT;
      else flen++;
    end
    if (ph == PH_HUNT) begin
      if (b == hdr[0]) begin
        ph = PH_HEADER;
        hpos = 1;
        flen = 1;
        fsel = 0;
        clear_field();
        fval[0] = '0;
        fval[1] = '0;
        type_byte = '0;
        access_byte = '0;
      end
    end else if (ph == PH_HEADER) begin
      if (b != hdr[hpos]) begin
        ph = PH_HUNT;
      end else begin
        hpos++;
        if (hpos >= 3) ph = PH_TYPE;
      end
    end else if (b == CH_HASH) begin
      if (ph == PH_FIELD) seal_field();
      frames++;
      cmd.kind = (type_byte == CH_UPPER_A) ? KIND_ANALOG :
                 (type_byte == CH_UPPER_D) ? KIND_DIGITAL : KIND_OTHER;
      cmd.access = access_byte;
      cmd.first = fval[0];
      cmd.second = fval[1];
      cmd.blocked = (cmd.kind != KIND_OTHER) && (($signed(fval[0]) < 11'sd2) || io_off);
      cmd.number = frames;
      commands_q.push_back(cmd);
      ph = PH_HUNT;
    end else if (b != CH_SPACE) begin
      case (ph)
        PH_TYPE: begin
          type_byte = b;
          ph = PH_ACCESS;
        end
        PH_ACCESS: begin
          access_byte = b;
          fsel = 0;
          clear_field();
          ph = PH_FIELD;
        end
        PH_FIELD: begin
          if (b == CH_COMMA) begin
            seal_field();
            next_field();
          end else begin
            if (fchars == 0 && (b == CH_MINUS || b == CH_PLUS)) begin
              fneg = (b == CH_MINUS);
            end else if (!digits_done && b >= CH_ZERO && b <= CH_NINE) begin
              fval[fsel] = param_t'(int'(fval[fsel]) * 10 + int'(b - CH_ZERO));
            end else begin
              digits_done = 1'b1;
            end
            fchars++;
            if (fchars >= 3) begin
              seal_field();
              ph = PH_SKIP;
            end
          end
        end
        PH_SKIP: next_field();
        default: ;
      endcase
    end
  endtask

  task automatic compare_field(input string what, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, got_v);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr[0] = HEADER_FIRST_RST;
      hdr[1] = HEADER_SECOND_RST;
      hdr[2] = HEADER_THIRD_RST;
      io_off = 1'b0;
      ph = PH_HUNT;
      hpos = 0;
      flen = 0;
      fsel = 0;
      clear_field();
      fval[0] = '0;
      fval[1] = '0;
      type_byte = '0;
      access_byte = '0;
      frames = '0;
      commands_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_HEADER_FIRST:  hdr[0] = pwdata[7:0];
          REG_HEADER_SECOND: hdr[1] = pwdata[7:0];
          REG_HEADER_THIRD:  hdr[2] = pwdata[7:0];
          REG_IO_DISABLED:   io_off = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (commands_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual frame %0d",
                   $time, out_frame_number);
          bad++;
        end else begin
          want = commands_q.pop_front();
          compare_field("command_kind", want.kind, out_command_kind);
          compare_field("access_byte", want.access, out_access_byte);
          compare_field("first_param", $signed(want.first), $signed(out_first_param));
          compare_field("second_param", $signed(want.second), $signed(out_second_param));
          compare_field("blocked", want.blocked, out_blocked);
          compare_field("frame_number", want.number, out_frame_number);
        end
      end
    end
    pending <= commands_q.size();
    mismatches <= bad;
  end
endmodule
`default_nettype wire

[test/ascii_command_frame_parser_tb.sv]
`default_nettype none
module ascii_command_frame_parser_tb;
  import acfp_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 212;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_command_kind;
  logic [7:0]  out_access_byte;
  param_t      out_first_param;
  param_t      out_second_param;
  logic        out_blocked;
  logic [15:0] out_frame_number;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          pending;
  int          mismatches;
  int          cycle_count = 0;
  int          sent_bytes = 0;
  int          target = 0;
  logic        idle_on = 1'b1;
  logic        long_hold = 1'b0;
  logic [7:0]  hdr[3] = '{HEADER_FIRST_RST, HEADER_SECOND_RST, HEADER_THIRD_RST};
  string       opening = "AXABTDW-99,999#ABT #";

  ascii_command_frame_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command_kind(out_command_kind), .out_access_byte(out_access_byte),
    .out_first_param(out_first_param), .out_second_param(out_second_param),
    .out_blocked(out_blocked), .out_frame_number(out_frame_number),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frame_decode_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command_kind(out_command_kind), .out_access_byte(out_access_byte),
    .out_first_param(out_first_param), .out_second_param(out_second_param),
    .out_blocked(out_blocked), .out_frame_number(out_frame_number),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ascii_command_frame_parser] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] any_but_hash();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_HASH);
    return b;
  endfunction

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CH_ZERO + 8'($urandom_range(0, 9));
      5, 6:          return CH_MINUS;
      7:             return CH_PLUS;
      default:       return any_but_hash();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_body(input logic [7:0] b);
    if ($urandom_range(0, 7) == 0) send_byte(CH_SPACE);
    send_byte(b);
  endtask

  task automatic send_field();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_body(field_char());
    if (n == 3) send_body(($urandom_range(0, 3) == 0) ? CH_COMMA : any_but_hash());
    else if ($urandom_range(0, 9) != 0) send_body(CH_COMMA);
  endtask

  task automatic send_frame();
    int style;
    int parts;
    logic [7:0] b;
    style = $urandom_range(0, 11);
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    send_byte(hdr[0]);
    if (style == 0) begin
      if ($urandom_range(0, 1)) send_byte(hdr[1]);
      do b = 8'($urandom_range(0, 255)); while (b == hdr[1] || b == hdr[2]);
      send_byte(b);
      return;
    end
    send_byte(hdr[1]);
    send_byte(hdr[2]);
    if (style == 1) begin
      repeat ($urandom_range(60, 72)) send_byte(any_but_hash());
      send_byte(CH_HASH);
      return;
    end
    parts = (style == 2) ? $urandom_range(0, 4) : 5;
    if (parts > 0) begin
      case ($urandom_range(0, 3))
        0: send_body(CH_UPPER_A);
        1: send_body(CH_UPPER_D);
        2: send_body("S");
        default: send_body(any_but_hash());
      endcase
    end
    if (parts > 1) send_body($urandom_range(0, 3) == 0 ? any_but_hash() :
                             ($urandom_range(0, 1) ? "W" : "R"));
    if (parts > 2) send_field();
    if (parts > 3) send_field();
    if (parts > 4) repeat ($urandom_range(0, 2)) send_body(any_but_hash());
    send_byte(CH_HASH);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1,
                             input logic [7:0] h2, input logic io);
    hdr[0] = h0;
    hdr[1] = h1;
    hdr[2] = h2;
    write_reg(REG_HEADER_FIRST, {24'd0, h0});
    write_reg(REG_HEADER_SECOND, {24'd0, h1});
    write_reg(REG_HEADER_THIRD, {24'd0, h2});
    write_reg(REG_IO_DISABLED, {31'd0, io});
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 4'd0;
    pwdata <= 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_headers(HEADER_FIRST_RST, HEADER_SECOND_RST, HEADER_THIRD_RST, 1'b0);
        1: begin
          set_headers(8'h00, 8'hFF, CH_SPACE, 1'b1);
          long_hold = 1'b1;
        end
        2: set_headers(any_but_hash(), any_but_hash(), any_but_hash(),
                       1'($urandom_range(0, 1)));
        default: begin
          set_headers(8'hFF, 8'h00, CH_UPPER_A, 1'b0);
          idle_on = 1'b0;
        end
      endcase
      target += PHASE_BYTES;
      while (sent_bytes < target) send_frame();
      send_byte(CH_HASH);
      settle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("[ascii_command_frame_parser] OK");
    end else begin
      $display("[ascii_command_frame_parser] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
